// ----- rtl/core/lrbf_pkg.sv -----
// ----------------------------------------------------------------------------
// lrbf_pkg
// Shared types and constants of the log record block fragmenter.
// ----------------------------------------------------------------------------
package lrbf_pkg;

    localparam int BLOCK_BYTES_DEF = 32768;
    localparam int HEADER_BYTES    = 7;
    localparam int MAX_RESULTS     = 34;
    localparam int RECORD_MAX      = 1048576;

    localparam int RECORD_W  = 21;
    localparam int PAD_W     = 3;
    localparam int PAYLOAD_W = 15;
    localparam int HDROFF_W  = 15;
    localparam int CNT_W     = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        FRAG_FULL   = 2'd0,
        FRAG_FIRST  = 2'd1,
        FRAG_MIDDLE = 2'd2,
        FRAG_LAST   = 2'd3
    } frag_type_t;

    typedef struct packed {
        logic [RECORD_W-1:0] record_length;
    } in_word_t;

    typedef struct packed {
        logic [PAD_W-1:0]     pad_bytes;
        frag_type_t           fragment_type;
        logic [PAYLOAD_W-1:0] payload_bytes;
        logic [RECORD_W-1:0]  record_offset;
        logic [HDROFF_W-1:0]  header_offset;
        logic                 last;
    } out_word_t;

endpackage

// ----- rtl/core/lrbf_stream_if.sv -----
// ----------------------------------------------------------------------------
// lrbf_stream_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface lrbf_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/log_record_block_fragmenter_core.sv -----
// ----------------------------------------------------------------------------
// log_record_block_fragmenter_core
// Plans the block fragments of one log record per input word.
// ----------------------------------------------------------------------------
// One record length is taken per input word; the block then emits one output
// word per fragment, one per cycle while the output side keeps up, and takes
// the next record after the last fragment is registered. A record is loaded
// in ST_IDLE, then its fragments are planned in ST_RUN by the single fragment
// step unit that the sequencer reuses for every fragment. The input is not
// ready while a record is being planned. Lengths above 1048576 are saturated,
// and the block offset carries over from one record to the next.
module log_record_block_fragmenter_core #(
    parameter int BLOCK_BYTES = lrbf_pkg::BLOCK_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lrbf_stream_if.sink          in_ch,
    lrbf_stream_if.source        out_ch
);
    import lrbf_pkg::*;

    localparam int POS_W = $clog2(BLOCK_BYTES + 1);
    localparam int BO_W  = $clog2(BLOCK_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t              state_reg,  state_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [RECORD_W-1:0] rem_reg,    rem_next;
    logic [RECORD_W-1:0] roff_reg,   roff_next;
    logic                first_reg,  first_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [BO_W-1:0]     boff_reg,   boff_next;
    logic                ovalid_reg, ovalid_next;
    out_word_t           odata_reg,  odata_next;

    out_word_t           step_word;
    logic [POS_W-1:0]    step_pos;
    logic [RECORD_W-1:0] step_rem;
    logic [RECORD_W-1:0] step_roff;
    logic                step_stop;
    logic                in_fire;
    logic                load_out;
    logic [RECORD_W-1:0] len_sat;

    lrbf_frag_unit #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .POS_W       (POS_W)
    ) u_frag (
        .pos            (pos_reg),
        .remaining      (rem_reg),
        .rec_off        (roff_reg),
        .first          (first_reg),
        .cap            (cnt_reg == CNT_W'(MAX_RESULTS - 1)),
        .word           (step_word),
        .next_pos       (step_pos),
        .next_remaining (step_rem),
        .next_rec_off   (step_roff),
        .stop           (step_stop)
    );

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign load_out     = (state_reg == ST_RUN) && (!ovalid_reg || out_ch.ready);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;
    assign len_sat      = (in_ch.data.record_length > RECORD_W'(RECORD_MAX))
                          ? RECORD_W'(RECORD_MAX) : in_ch.data.record_length;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        roff_next   = roff_reg;
        first_next  = first_reg;
        cnt_next    = cnt_reg;
        boff_next   = boff_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;

        if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pos_next   = POS_W'(boff_reg);
                    rem_next   = len_sat;
                    roff_next  = '0;
                    first_next = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (load_out)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = step_word;
                    pos_next    = step_pos;
                    rem_next    = step_rem;
                    roff_next   = step_roff;
                    first_next  = 1'b0;
                    cnt_next    = cnt_reg + 1'b1;
                    if (step_stop)
                    begin
                        boff_next  = (step_pos == POS_W'(BLOCK_BYTES))
                                     ? '0 : BO_W'(step_pos);
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            rem_reg    <= '0;
            roff_reg   <= '0;
            first_reg  <= 1'b0;
            cnt_reg    <= '0;
            boff_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            roff_reg   <= roff_next;
            first_reg  <= first_next;
            cnt_reg    <= cnt_next;
            boff_reg   <= boff_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

endmodule

// ----- rtl/core/lrbf_frag_unit.sv -----
// ----------------------------------------------------------------------------
// lrbf_frag_unit
// Shared fragment step: plans one fragment from the running position,
// remaining length and record offset, and gives the values after it.
// ----------------------------------------------------------------------------
module lrbf_frag_unit #(
    parameter int BLOCK_BYTES = lrbf_pkg::BLOCK_BYTES_DEF,
    parameter int POS_W       = $clog2(BLOCK_BYTES + 1)
) (
    input  logic [POS_W-1:0]              pos,
    input  logic [lrbf_pkg::RECORD_W-1:0] remaining,
    input  logic [lrbf_pkg::RECORD_W-1:0] rec_off,
    input  logic                          first,
    input  logic                          cap,
    output lrbf_pkg::out_word_t           word,
    output logic [POS_W-1:0]              next_pos,
    output logic [lrbf_pkg::RECORD_W-1:0] next_remaining,
    output logic [lrbf_pkg::RECORD_W-1:0] next_rec_off,
    output logic                          stop
);
    import lrbf_pkg::*;

    localparam logic [POS_W-1:0] BLK = POS_W'(BLOCK_BYTES);
    localparam logic [POS_W-1:0] HDR = POS_W'(HEADER_BYTES);

    logic [POS_W-1:0]    left;
    logic                short_left;
    logic [POS_W-1:0]    pos_eff;
    logic [POS_W-1:0]    avail;
    logic [RECORD_W-1:0] avail_ext;
    logic [RECORD_W-1:0] size;
    logic                fits;
    frag_type_t          ftype;

    always_comb
    begin
        left       = BLK - pos;
        short_left = (left < HDR);
        pos_eff    = short_left ? '0 : pos;
        avail      = BLK - pos_eff - HDR;
        avail_ext  = RECORD_W'(avail);
        fits       = (remaining <= avail_ext);
        size       = fits ? remaining : avail_ext;

        if (first && fits)
        begin
            ftype = FRAG_FULL;
        end
        else if (first)
        begin
            ftype = FRAG_FIRST;
        end
        else if (fits)
        begin
            ftype = FRAG_LAST;
        end
        else
        begin
            ftype = FRAG_MIDDLE;
        end

        stop           = fits || cap;
        next_pos       = pos_eff + HDR + POS_W'(size);
        next_remaining = remaining - size;
        next_rec_off   = rec_off + size;

        word.pad_bytes     = short_left ? PAD_W'(left) : '0;
        word.fragment_type = ftype;
        word.payload_bytes = PAYLOAD_W'(size);
        word.record_offset = rec_off;
        word.header_offset = HDROFF_W'(pos_eff);
        word.last          = stop;
    end

endmodule

// ----- rtl/core/lrbf_checker.sv -----
// ----------------------------------------------------------------------------
// lrbf_checker
// Port-level checks of the fragmenter, bound to the top level.
// ----------------------------------------------------------------------------
module lrbf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input lrbf_pkg::out_word_t out_data
);
    import lrbf_pkg::*;

    // hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // drop ready once a record is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready while planning a record");

    a_nonlast_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |->
            out_data.fragment_type == FRAG_FIRST ||
            out_data.fragment_type == FRAG_MIDDLE)
        else $error("non-final fragment with full or last type");

    a_start_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.fragment_type == FRAG_FULL ||
                      out_data.fragment_type == FRAG_FIRST) |->
            out_data.record_offset == '0)
        else $error("opening fragment with nonzero record offset");

endmodule

bind log_record_block_fragmenter_core lrbf_checker u_lrbf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

// ----- tb/log_record_block_fragmenter_core_tb.sv -----
// ----------------------------------------------------------------------------
// log_record_block_fragmenter_core_tb
// Self-checking testbench of the log record block fragmenter. A table of
// directed record lengths comes first: zero and maximum lengths, saturation,
// header padding, zero-size fragments and block-end crossings. Random records
// follow, many of them sized to land near the block end. Each fragment word is
// checked field by field against a table word or a local block-offset planner.
// ----------------------------------------------------------------------------
module log_record_block_fragmenter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lrbf_pkg::*;

    localparam int BLOCK        = BLOCK_BYTES_DEF;
    localparam int RANDOM_ITEMS = 258;
    localparam int QUIET_ITEMS  = 40;
    localparam int DRAIN_CYCLES = 2 * MAX_RESULTS + 8;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum logic {
        ROW_FIXED,
        ROW_FILL
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        int unsigned value;
        bit          typed;
        out_word_t   want;
    } stim_row_t;

    localparam out_word_t NO_WORD = '0;

    stim_row_t directed [22] = '{
        '{ROW_FIXED, 0,        1'b1, '{3'd0, FRAG_FULL, 15'd0, 21'd0, 15'd0, 1'b1}},
        '{ROW_FIXED, 1,        1'b1, '{3'd0, FRAG_FULL, 15'd1, 21'd0, 15'd7, 1'b1}},
        '{ROW_FIXED, 32761,    1'b0, NO_WORD},
        '{ROW_FIXED, 2097151,  1'b0, NO_WORD},
        '{ROW_FIXED, 1048576,  1'b0, NO_WORD},
        '{ROW_FIXED, 1048577,  1'b0, NO_WORD},
        '{ROW_FILL,  3,        1'b0, NO_WORD},
        '{ROW_FIXED, 10,       1'b1, '{3'd3, FRAG_FULL, 15'd10, 21'd0, 15'd0, 1'b1}},
        '{ROW_FILL,  7,        1'b0, NO_WORD},
        '{ROW_FIXED, 0,        1'b1, '{3'd0, FRAG_FULL, 15'd0, 21'd0, 15'd32761, 1'b1}},
        '{ROW_FILL,  7,        1'b0, NO_WORD},
        '{ROW_FIXED, 100,      1'b0, NO_WORD},
        '{ROW_FILL,  0,        1'b0, NO_WORD},
        '{ROW_FIXED, 5,        1'b1, '{3'd0, FRAG_FULL, 15'd5, 21'd0, 15'd0, 1'b1}},
        '{ROW_FILL,  6,        1'b0, NO_WORD},
        '{ROW_FIXED, 32761,    1'b1, '{3'd6, FRAG_FULL, 15'd32761, 21'd0, 15'd0, 1'b1}},
        '{ROW_FIXED, 32762,    1'b0, NO_WORD},
        '{ROW_FIXED, 'h0AAAAA, 1'b0, NO_WORD},
        '{ROW_FIXED, 'h155555, 1'b0, NO_WORD},
        '{ROW_FILL,  1,        1'b0, NO_WORD},
        '{ROW_FIXED, 65522,    1'b0, NO_WORD},
        '{ROW_FIXED, 1048575,  1'b0, NO_WORD}
    };

    logic clk = 1'b0;
    logic rst_n;

    lrbf_stream_if #(.word_t(in_word_t))  in_if ();
    lrbf_stream_if #(.word_t(out_word_t)) out_if ();

    out_word_t   frag_expect [$];
    out_word_t   planned [$];
    int unsigned block_pos;
    int          mismatches;
    int          cycles;
    int          ready_hold;
    bit          quiet;
    int          records_sent;
    int          split_records;
    int          frags_seen;
    int          padded_seen;

    log_record_block_fragmenter_core #(
        .BLOCK_BYTES(BLOCK)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    always #10 clk = ~clk;

    function automatic void plan_fragments(input logic [RECORD_W-1:0] len);
        int unsigned remaining;
        int unsigned pos;
        int unsigned rec_off;
        int unsigned left;
        int unsigned pad;
        int unsigned avail;
        int unsigned size;
        int          count;
        bit          opening;
        bit          closing;
        bit          stop;
        out_word_t   w;
        planned.delete();
        remaining = 32'(len);
        if (remaining > RECORD_MAX)
            remaining = RECORD_MAX;
        pos = block_pos;
        if (pos >= BLOCK)
            pos = 0;
        rec_off = 0;
        opening = 1'b1;
        count = 0;
        stop = 1'b0;
        while (!stop)
        begin
            left = BLOCK - pos;
            pad = 0;
            if (left < HEADER_BYTES)
            begin
                pad = left;
                pos = 0;
            end
            avail = BLOCK - pos - HEADER_BYTES;
            size = (remaining < avail) ? remaining : avail;
            closing = (size == remaining);
            stop = closing || (count + 1 >= MAX_RESULTS);
            if (opening && closing)
                w.fragment_type = FRAG_FULL;
            else if (opening)
                w.fragment_type = FRAG_FIRST;
            else if (closing)
                w.fragment_type = FRAG_LAST;
            else
                w.fragment_type = FRAG_MIDDLE;
            w.pad_bytes      = pad[PAD_W-1:0];
            w.payload_bytes  = size[PAYLOAD_W-1:0];
            w.record_offset  = rec_off[RECORD_W-1:0];
            w.header_offset  = pos[HDROFF_W-1:0];
            w.last           = stop;
            planned.insert(planned.size(), w);
            count++;
            pos += HEADER_BYTES + size;
            rec_off += size;
            remaining -= size;
            opening = 1'b0;
        end
        block_pos = pos % BLOCK;
    endfunction

    // length that leaves exactly keep bytes in the block after the record
    function automatic logic [RECORD_W-1:0] fill_length(input int keep);
        int p;
        int n;
        p = block_pos;
        if (BLOCK - p < HEADER_BYTES)
            p = 0;
        n = BLOCK - keep - p - HEADER_BYTES;
        if (n < 0)
            n += BLOCK - HEADER_BYTES;
        return n[RECORD_W-1:0];
    endfunction

    function automatic logic [RECORD_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return RECORD_W'($urandom_range(0, 200));
        else if (roll < 50)
            return RECORD_W'($urandom_range(0, BLOCK - 1));
        else if (roll < 70)
            return fill_length($urandom_range(0, HEADER_BYTES + 1));
        else if (roll < 82)
            return RECORD_W'($urandom_range(BLOCK, 300000));
        else if (roll < 90)
            return RECORD_W'($urandom_range(300001, RECORD_MAX));
        else if (roll < 95)
            return RECORD_W'($urandom_range(RECORD_MAX + 1, (1 << RECORD_W) - 1));
        else
            return RECORD_W'($urandom());
    endfunction

    task automatic idle_input(input int n);
        in_if.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_record(input logic [RECORD_W-1:0] len, input bit typed,
                               input out_word_t want);
        in_if.valid <= 1'b1;
        in_if.data.record_length <= len;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        plan_fragments(len);
        if (typed)
            frag_expect.insert(frag_expect.size(), want);
        else
            foreach (planned[i])
                frag_expect.insert(frag_expect.size(), planned[i]);
        records_sent++;
        if (planned.size() > 1)
            split_records++;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (quiet)
            out_if.ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if ($urandom_range(0, 3) == 0)
        begin
            out_if.ready <= 1'b0;
            ready_hold <= $urandom_range(0, 16);
        end
        else
        begin
            out_if.ready <= 1'b1;
            ready_hold <= $urandom_range(0, 19);
        end
    end

    always @(posedge clk)
    begin : frag_monitor
        out_word_t got;
        out_word_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got = out_if.data;
            frags_seen++;
            if (got.pad_bytes != 0)
                padded_seen++;
            if (frag_expect.size() == 0)
            begin
                $error("fragment word with nothing expected: type %0d size %0d",
                       got.fragment_type, got.payload_bytes);
                mismatches++;
            end
            else
            begin
                want = frag_expect.pop_front();
                if (got.pad_bytes !== want.pad_bytes)
                begin
                    $error("pad_bytes: expected %0d, got %0d",
                           want.pad_bytes, got.pad_bytes);
                    mismatches++;
                end
                if (got.fragment_type !== want.fragment_type)
                begin
                    $error("fragment_type: expected %0d, got %0d",
                           want.fragment_type, got.fragment_type);
                    mismatches++;
                end
                if (got.payload_bytes !== want.payload_bytes)
                begin
                    $error("payload_bytes: expected %0d, got %0d",
                           want.payload_bytes, got.payload_bytes);
                    mismatches++;
                end
                if (got.record_offset !== want.record_offset)
                begin
                    $error("record_offset: expected %0d, got %0d",
                           want.record_offset, got.record_offset);
                    mismatches++;
                end
                if (got.header_offset !== want.header_offset)
                begin
                    $error("header_offset: expected %0d, got %0d",
                           want.header_offset, got.header_offset);
                    mismatches++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        block_pos = 0;
        mismatches = 0;
        cycles = 0;
        ready_hold = 0;
        quiet = 1'b0;
        records_sent = 0;
        split_records = 0;
        frags_seen = 0;
        padded_seen = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if ($urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 17));
            if (directed[i].kind == ROW_FILL)
                send_record(fill_length(directed[i].value), 1'b0, NO_WORD);
            else
                send_record(directed[i].value[RECORD_W-1:0], directed[i].typed,
                            directed[i].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            else if ($urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 17));
            send_record(pick_length(), 1'b0, NO_WORD);
        end
        in_if.valid <= 1'b0;
        quiet = 1'b1;

        while (frag_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (frag_expect.size() != 0)
        begin
            $error("%0d fragment words never arrived", frag_expect.size());
            mismatches++;
        end
        $display("Fragmented %0d records into %0d words, %0d of them split across blocks.",
                 records_sent, frags_seen, split_records);
        $display("Header padding seen on %0d words, %0d field mismatches.",
                 padded_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- log_record_block_fragmenter_core.f -----
rtl/core/lrbf_pkg.sv
rtl/core/lrbf_stream_if.sv
rtl/core/lrbf_frag_unit.sv
rtl/core/log_record_block_fragmenter_core.sv
rtl/core/lrbf_checker.sv
tb/log_record_block_fragmenter_core_tb.sv
